>>> rtl/core/qnorm_pkg.sv
package qnorm_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 14;

endpackage

>>> rtl/core/quaternion_normalizer.sv
// Quaternion normalizer: accepts one beat per cycle unless stalled and returns the
// floored norm and each component scaled by 2^FRACTION_BITS over that norm,
// truncated toward zero. The input registers (magnitudes and signs, then sum of
// squares) feed a chain of square-root cells, one root bit each, then a chain of
// divider cells, one quotient bit each. A zero norm raises zero_error with all
// components zero. The pipeline stalls as a whole while the output beat is not
// taken.
module quaternion_normalizer
    import qnorm_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // in_w, in_x, in_y, in_z
    input  logic [4*COMPONENT_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // magnitude, out_w, out_x, out_y, out_z, zero padding
    output logic [((COMPONENT_BITS+1+4*(FRACTION_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // zero_error
    output logic                          m_axis_tuser
);

    localparam int CB   = COMPONENT_BITS;
    localparam int MB   = CB + 1;
    localparam int SB   = 2 * CB + 2;
    localparam int NB   = CB + FRACTION_BITS + 1;
    localparam int OB   = FRACTION_BITS + 2;
    localparam int PB   = 4 * MB + 4;
    localparam int DW   = ((MB + 4 * OB + 7) / 8) * 8;

    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: magnitudes and signs; payload = {signs, mags}
    logic          r_v1;
    logic [PB-1:0] r_p1;
    logic [PB-1:0] n_p1;

    always_comb begin
        logic [CB-1:0] c;
        for (int k = 0; k < 4; k++) begin
            c = s_axis_tdata[k*CB +: CB];
            n_p1[4*MB + k] = c[CB-1];
            n_p1[k*MB +: MB] = c[CB-1] ? ({1'b0, ~c} + MB'(1)) : {1'b0, c};
        end
    end

    // stage 2: sum of squares
    logic          r_v2;
    logic [PB-1:0] r_p2;
    logic [SB-1:0] r_sum;
    logic [SB-1:0] w_sq[4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sq[k] = SB'(r_p1[k*MB +: MB]) * SB'(r_p1[k*MB +: MB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1  <= n_p1;
            r_p2  <= r_p1;
            r_sum <= w_sq[0] + w_sq[1] + w_sq[2] + w_sq[3];
        end
    end

    logic          sq_v   [MB+1];
    logic [SB-1:0] sq_rem [MB+1];
    logic [MB-1:0] sq_root[MB+1];
    logic [PB-1:0] sq_pay [MB+1];

    assign sq_v[0]    = r_v2;
    assign sq_rem[0]  = r_sum;
    assign sq_root[0] = '0;
    assign sq_pay[0]  = r_p2;

    for (genvar g = 0; g < MB; g++) begin : g_sqrt
        qnorm_sqrt_cell #(
            .SUM_BITS(SB), .ROOT_BITS(MB), .STEP(g), .PAY_BITS(PB)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(sq_v[g]), .i_rem(sq_rem[g]), .i_root(sq_root[g]), .i_pay(sq_pay[g]),
            .o_valid(sq_v[g+1]), .o_rem(sq_rem[g+1]), .o_root(sq_root[g+1]),
            .o_pay(sq_pay[g+1])
        );
    end

    logic            dv_v  [NB+1];
    logic [MB-1:0]   dv_den[NB+1];
    logic [4*MB-1:0] dv_rem[NB+1];
    logic [4*NB-1:0] dv_num[NB+1];
    logic [PB-1:0]   dv_pay[NB+1];

    assign dv_v[0]   = sq_v[MB];
    assign dv_den[0] = sq_root[MB];
    assign dv_rem[0] = '0;
    assign dv_pay[0] = sq_pay[MB];
    assign dv_num[0] = {sq_pay[MB][3*MB +: MB], FRACTION_BITS'(0),
                        sq_pay[MB][2*MB +: MB], FRACTION_BITS'(0),
                        sq_pay[MB][MB +: MB], FRACTION_BITS'(0),
                        sq_pay[MB][0 +: MB], FRACTION_BITS'(0)};

    for (genvar g = 0; g < NB; g++) begin : g_div
        qnorm_div_cell #(
            .NUM_BITS(NB), .DEN_BITS(MB), .STEP(g), .PAY_BITS(PB)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(dv_v[g]), .i_den(dv_den[g]), .i_rem(dv_rem[g]), .i_num(dv_num[g]),
            .i_pay(dv_pay[g]),
            .o_valid(dv_v[g+1]), .o_den(dv_den[g+1]), .o_rem(dv_rem[g+1]),
            .o_num(dv_num[g+1]), .o_pay(dv_pay[g+1])
        );
    end

    logic [DW-1:0] w_data;
    logic          w_zero;

    always_comb begin
        logic [OB-1:0] q;
        w_zero = (dv_den[NB] == '0);
        w_data = '0;
        w_data[0 +: MB] = dv_den[NB];
        for (int k = 0; k < 4; k++) begin
            q = dv_num[NB][k*NB +: OB];
            if (dv_pay[NB][4*MB + k]) begin
                q = ~q + OB'(1);
            end
            if (w_zero) begin
                q = '0;
            end
            w_data[MB + k*OB +: OB] = q;
        end
    end

    assign m_axis_tvalid = dv_v[NB];
    assign m_axis_tdata  = w_data;
    assign m_axis_tuser  = w_zero;

endmodule

>>> rtl/core/qnorm_sqrt_cell.sv
module qnorm_sqrt_cell
    import qnorm_pkg::*;
#(
    parameter int SUM_BITS  = 34,
    parameter int ROOT_BITS = 17,
    parameter int STEP      = 0,
    parameter int PAY_BITS  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [SUM_BITS-1:0]  i_rem,
    input  logic [ROOT_BITS-1:0] i_root,
    input  logic [PAY_BITS-1:0]  i_pay,
    output logic                 o_valid,
    output logic [SUM_BITS-1:0]  o_rem,
    output logic [ROOT_BITS-1:0] o_root,
    output logic [PAY_BITS-1:0]  o_pay
);

    localparam int SHIFT = 2 * (ROOT_BITS - 1 - STEP);

    logic [SUM_BITS+1:0] w_trial;
    logic [SUM_BITS+1:0] w_rem_ext;
    logic [ROOT_BITS-1:0] w_bit;

    assign w_bit     = ROOT_BITS'(1) << (ROOT_BITS - 1 - STEP);
    assign w_rem_ext = {2'b00, i_rem};
    assign w_trial   = ({(SUM_BITS + 2 - ROOT_BITS)'(0), i_root} << (ROOT_BITS - STEP))
                     + ((SUM_BITS + 2)'(1) << SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pay <= i_pay;
            if (w_rem_ext >= w_trial) begin
                o_rem  <= SUM_BITS'(w_rem_ext - w_trial);
                o_root <= i_root | w_bit;
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
        end
    end

endmodule

>>> rtl/core/qnorm_div_cell.sv
module qnorm_div_cell
    import qnorm_pkg::*;
#(
    parameter int NUM_BITS = 31,
    parameter int DEN_BITS = 17,
    parameter int STEP     = 0,
    parameter int PAY_BITS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [DEN_BITS-1:0]       i_den,
    input  logic [4*DEN_BITS-1:0]     i_rem,
    input  logic [4*NUM_BITS-1:0]     i_num,
    input  logic [PAY_BITS-1:0]       i_pay,
    output logic                      o_valid,
    output logic [DEN_BITS-1:0]       o_den,
    output logic [4*DEN_BITS-1:0]     o_rem,
    output logic [4*NUM_BITS-1:0]     o_num,
    output logic [PAY_BITS-1:0]       o_pay
);

    logic [4*DEN_BITS-1:0] n_rem;
    logic [4*NUM_BITS-1:0] n_num;

    always_comb begin
        logic [DEN_BITS:0] t;
        for (int k = 0; k < 4; k++) begin
            t = {i_rem[k*DEN_BITS +: DEN_BITS], i_num[k*NUM_BITS + NUM_BITS-1]};
            n_num[k*NUM_BITS +: NUM_BITS] = {i_num[k*NUM_BITS +: NUM_BITS-1], 1'b0};
            if (t >= {1'b0, i_den}) begin
                t = t - {1'b0, i_den};
                n_num[k*NUM_BITS] = 1'b1;
            end
            n_rem[k*DEN_BITS +: DEN_BITS] = t[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den <= i_den;
            o_rem <= n_rem;
            o_num <= n_num;
            o_pay <= i_pay;
        end
    end

endmodule

>>> verif/tb_quaternion_normalizer.sv
`timescale 1ns / 1ps

module tb_quaternion_normalizer;
    import qnorm_pkg::*;

    localparam int CB = COMPONENT_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam int OW = FB + 2;
    localparam int MW = CB + 1;
    localparam int TDW = ((MW + 4 * OW + 7) / 8) * 8;
    localparam int LATENCY = 2 + (CB + 1) + (CB + FB + 1);

    typedef struct packed {
        logic [MW-1:0] mag;
        logic [OW-1:0] w;
        logic [OW-1:0] x;
        logic [OW-1:0] y;
        logic [OW-1:0] z;
        logic          zero;
    } norm_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [4*CB-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [TDW-1:0]   m_axis_tdata;
    logic             m_axis_tuser;

    norm_t expected_norms[$];
    int    mismatch_count = 0;
    int    sink_wait = 0;
    bit    sink_idle = 0;

    quaternion_normalizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic norm_t normalize(input logic [4*CB-1:0] q);
        norm_t r;
        logic [63:0] a[4];
        logic [63:0] sum;
        logic [63:0] nrm;
        logic [63:0] quo;
        logic [OW-1:0] outs[4];
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = q[i*CB+CB-1] ? (64'd1 << CB) - q[i*CB +: CB] : q[i*CB +: CB];
            sum = sum + a[i] * a[i];
        end
        nrm = int_sqrt(sum);
        for (int i = 0; i < 4; i++) begin
            if (nrm == 0) begin
                outs[i] = '0;
            end else begin
                quo = (a[i] << FB) / nrm;
                if (q[i*CB+CB-1]) quo = -quo;
                outs[i] = quo[OW-1:0];
            end
        end
        r.mag = nrm[MW-1:0];
        r.w = outs[0];
        r.x = outs[1];
        r.y = outs[2];
        r.z = outs[3];
        r.zero = (nrm == 0);
        return r;
    endfunction

    // hold valid between beats of a burst; drop it only before a gap
    task automatic send_quat(input logic [CB-1:0] w, x, y, z, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x, w};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_norms.push_back(normalize({z, y, x, w}));
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return CB'($signed($urandom_range(0, 6)) - 3);
            3: return CB'($signed($urandom_range(0, 400)) - 200);
            default: return CB'($urandom);
        endcase
    endfunction

    // after each taken beat, hold ready low for a randomly drawn wait unless sink_idle is set
    always @(posedge i_clk) begin
        norm_t got;
        norm_t exp_n;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.mag = m_axis_tdata[0 +: MW];
                got.w = m_axis_tdata[MW +: OW];
                got.x = m_axis_tdata[MW+OW +: OW];
                got.y = m_axis_tdata[MW+2*OW +: OW];
                got.z = m_axis_tdata[MW+3*OW +: OW];
                got.zero = m_axis_tuser;
                if (expected_norms.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected beat %h", got);
                end else begin
                    exp_n = expected_norms.pop_front();
                    if (got !== exp_n) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch exp mag=%0d w=%h x=%h y=%h z=%h e=%b",
                                exp_n.mag, exp_n.w, exp_n.x, exp_n.y, exp_n.z, exp_n.zero);
                            $display("         got mag=%0d w=%h x=%h y=%h z=%h e=%b",
                                got.mag, got.w, got.x, got.y, got.z, got.zero);
                        end
                    end
                end
                sink_wait = sink_idle ? 0 : $urandom_range(0, 5);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_axis_tready <= (sink_wait == 0);
        end
    end

    task automatic test_directed();
        logic [CB-1:0] v[6];
        v = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0003};
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1);
        send_quat(16'h0000, 16'hffff, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000, 0);
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001, 2);
        send_quat(16'h0003, 16'h0004, 16'h0000, 16'h0000, 0);
        for (int i = 0; i < 12; i++)
            send_quat(v[i % 6], v[(i + 1) % 6], v[(i + 2) % 6], v[(i + 3) % 6], 0);
        end_burst();
    endtask

    task automatic test_drain_pause();
        while (expected_norms.size() != 0) @(posedge i_clk);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h1234, 16'hedcb, 16'h0042, 16'h8000, 0);
        end_burst();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 < 40) sink_idle = 1;
            else sink_idle = 0;
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      (i % 150 < 30) ? 0 : $urandom_range(0, 5));
        end
        end_burst();
        sink_idle = 0;
    endtask

    task automatic test_back_to_back(input int count);
        sink_idle = 1;
        for (int i = 0; i < count; i++)
            send_quat(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), 0);
        end_burst();
        sink_idle = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random(800);
        test_back_to_back(80);
        sink_idle = 1;
        while (expected_norms.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_norms.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/qnorm_pkg.sv
rtl/core/qnorm_sqrt_cell.sv
rtl/core/qnorm_div_cell.sv
rtl/core/quaternion_normalizer.sv
verif/tb_quaternion_normalizer.sv
